FILE: src/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and codes for the keypad code lock
// Key codes, phase and event encodings, reset constants and the result beat.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // Default number of key slots in a code
  localparam int DEFAULT_CODE_SLOTS = 16;

  // Factory code is 1,2,3,4,5
  localparam int RESET_CODE_LEN = 5;

  localparam logic [3:0] LIMIT_RESET  = 4'd5;
  localparam logic [3:0] MAX_FAILURES = 4'd15;

  // Key codes
  localparam logic [3:0] KEY_STAR = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;

  // Phase codes
  localparam logic [2:0] PHASE_MENU    = 3'd0;
  localparam logic [2:0] PHASE_VERIFY  = 3'd1;
  localparam logic [2:0] PHASE_OLD     = 3'd2;
  localparam logic [2:0] PHASE_NEW     = 3'd3;
  localparam logic [2:0] PHASE_CONFIRM = 3'd4;
  localparam logic [2:0] PHASE_LOCKED  = 3'd5;

  // Event codes
  localparam logic [2:0] EV_TAKEN     = 3'd0;
  localparam logic [2:0] EV_GRANTED   = 3'd1;
  localparam logic [2:0] EV_RETRY     = 3'd2;
  localparam logic [2:0] EV_LOCKED    = 3'd3;
  localparam logic [2:0] EV_CHANGED   = 3'd4;
  localparam logic [2:0] EV_MISMATCH  = 3'd5;
  localparam logic [2:0] EV_OLD_WRONG = 3'd6;
  localparam logic [2:0] EV_IGNORED   = 3'd7;

  // One result beat
  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] phase;
    logic [4:0] entered_count;
    logic [3:0] failure_total;
  } result_t;

endpackage

FILE: src/kcl_in_stage.sv
// ----------------------------------------------------------------------------
// kcl_in_stage: input key register
// Holds one accepted key until the core consumes it.
// ----------------------------------------------------------------------------
module kcl_in_stage
  import kcl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] key_code,
  input  logic       advance,
  output logic       held_valid,
  output logic [3:0] held_key
);

  logic load;

  // Stall only while a held key cannot move on this cycle
  assign in_stall = held_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_key <= key_code;
    end
  end

endmodule

FILE: src/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core: code lock state and single-pass step logic
// Holds phase, codes, lengths and failure count; one key per unstalled cycle.
// ----------------------------------------------------------------------------
module kcl_core
  import kcl_pkg::*;
#(
  parameter int CODE_SLOTS = DEFAULT_CODE_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [3:0] cfg_wdata,
  input  logic       advance,
  input  logic [3:0] key,
  output result_t    result
);

  localparam int LEN_W   = $clog2(CODE_SLOTS + 1);
  localparam int CNT_W   = LEN_W + 5;
  localparam int RST_LEN = (CODE_SLOTS < RESET_CODE_LEN) ? CODE_SLOTS : RESET_CODE_LEN;

  typedef enum logic [2:0] {
    S_MENU    = PHASE_MENU,
    S_VERIFY  = PHASE_VERIFY,
    S_OLD     = PHASE_OLD,
    S_NEW     = PHASE_NEW,
    S_CONFIRM = PHASE_CONFIRM,
    S_LOCKED  = PHASE_LOCKED
  } phase_t;

  phase_t           phase_reg, phase_next;
  logic [LEN_W-1:0] entry_len, entry_len_next;
  logic [LEN_W-1:0] saved_len, saved_len_next;
  logic [LEN_W-1:0] new_len, new_len_next;
  logic [3:0]       fail_cnt, fail_cnt_next;
  logic [3:0]       lockout_limit;

  logic [3:0] saved_code [CODE_SLOTS];
  logic [3:0] entry_keys [CODE_SLOTS];
  logic [3:0] new_keys   [CODE_SLOTS];

  logic [CODE_SLOTS-1:0] saved_ok, new_ok;
  logic                  saved_hit, new_hit;
  logic                  wr_key, copy_new, copy_saved;
  logic [3:0]            limit_eff, fail_inc;
  logic [CNT_W-1:0]      cnt_wide;
  logic [2:0]            ev;

  // Slot-by-slot compare; slots past the entry length are don't-care
  for (genvar i = 0; i < CODE_SLOTS; i++) begin : g_slot
    assign saved_ok[i] = !(LEN_W'(i) < entry_len) || (entry_keys[i] == saved_code[i]);
    assign new_ok[i]   = !(LEN_W'(i) < entry_len) || (entry_keys[i] == new_keys[i]);
  end

  assign saved_hit = (entry_len == saved_len) && (&saved_ok);
  assign new_hit   = (entry_len == new_len) && (&new_ok);

  assign limit_eff = (lockout_limit == 4'd0) ? 4'd1 : lockout_limit;
  assign fail_inc  = (fail_cnt != MAX_FAILURES) ? fail_cnt + 4'd1 : fail_cnt;

  always_comb begin
    phase_next     = phase_reg;
    entry_len_next = entry_len;
    saved_len_next = saved_len;
    new_len_next   = new_len;
    fail_cnt_next  = fail_cnt;
    ev             = EV_TAKEN;
    cnt_wide       = '0;
    wr_key         = 1'b0;
    copy_new       = 1'b0;
    copy_saved     = 1'b0;

    case (phase_reg)
      S_MENU: begin
        if (key == KEY_STAR) begin
          phase_next     = S_VERIFY;
          entry_len_next = '0;
        end else if (key == KEY_HASH) begin
          phase_next     = S_OLD;
          entry_len_next = '0;
        end else begin
          ev = EV_IGNORED;
        end
      end
      S_VERIFY, S_OLD, S_NEW, S_CONFIRM: begin
        if (key != KEY_STAR && entry_len < LEN_W'(CODE_SLOTS)) begin
          wr_key         = 1'b1;
          entry_len_next = entry_len + 1'b1;
          cnt_wide       = CNT_W'(entry_len) + 1'b1;
        end else begin
          entry_len_next = '0;
          case (phase_reg)
            S_VERIFY: begin
              if (saved_hit) begin
                fail_cnt_next = '0;
                ev            = EV_GRANTED;
                phase_next    = S_MENU;
              end else begin
                fail_cnt_next = fail_inc;
                if (fail_inc >= limit_eff) begin
                  ev         = EV_LOCKED;
                  phase_next = S_LOCKED;
                end else begin
                  ev         = EV_RETRY;
                  phase_next = S_MENU;
                end
              end
            end
            S_OLD: begin
              if (saved_hit) begin
                phase_next = S_NEW;
              end else begin
                ev         = EV_OLD_WRONG;
                phase_next = S_MENU;
              end
            end
            S_NEW: begin
              copy_new     = 1'b1;
              new_len_next = entry_len;
              phase_next   = S_CONFIRM;
            end
            default: begin
              if (new_hit) begin
                copy_saved     = 1'b1;
                saved_len_next = entry_len;
                ev             = EV_CHANGED;
              end else begin
                ev = EV_MISMATCH;
              end
              phase_next = S_MENU;
            end
          endcase
        end
      end
      default: begin
        phase_next = S_LOCKED;
        ev         = EV_IGNORED;
      end
    endcase

    result.event_res     = ev;
    result.phase         = phase_next;
    result.entered_count = cnt_wide[4:0];
    result.failure_total = fail_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= S_MENU;
      entry_len     <= '0;
      saved_len     <= LEN_W'(RST_LEN);
      new_len       <= '0;
      fail_cnt      <= '0;
      lockout_limit <= LIMIT_RESET;
    end else begin
      if (cfg_wen) begin
        lockout_limit <= cfg_wdata;
      end
      if (advance) begin
        phase_reg <= phase_next;
        entry_len <= entry_len_next;
        saved_len <= saved_len_next;
        new_len   <= new_len_next;
        fail_cnt  <= fail_cnt_next;
      end
    end
  end

  // Stored code: factory value on reset, overwritten on a confirmed change
  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_SLOTS; i++) begin
      if (rst) begin
        saved_code[i] <= (i < RST_LEN) ? 4'(i + 1) : 4'd0;
      end else if (advance && copy_saved) begin
        saved_code[i] <= entry_keys[i];
      end
    end
  end

  // Entry and first-new-code registers need no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_SLOTS; i++) begin
      if (advance && wr_key && entry_len == LEN_W'(i)) begin
        entry_keys[i] <= key;
      end
      if (advance && copy_new) begin
        new_keys[i] <= entry_keys[i];
      end
    end
  end

endmodule

FILE: src/kcl_out_stage.sv
// ----------------------------------------------------------------------------
// kcl_out_stage: result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module kcl_out_stage
  import kcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  result_t result_in,
  output logic    slot_free,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t result_out
);

  // Free when empty or when the held beat leaves this cycle
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_out <= result_in;
    end
  end

endmodule

FILE: src/keypad_code_lock_controller.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_controller: keypad code lock, one key per unstalled cycle
// Verify, change-code and lockout handling for decoded keypad keys.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   key     | in        | in_valid/in_stall  | key_code
//   result  | out       | out_valid/out_stall| event_res, phase, entered_count,
//           |           |                    | failure_total
//   config  | in        | cfg_wen            | cfg_wdata (lockout limit)
//
// Each key passes through the key register and then the result register: the
// step logic works on the key register and loads the result register, and the
// beat leaves when out_stall is low. Throughput is one key per cycle, while
// results are not stalled; the code compare is parallel over all slots.
// Reset is synchronous: factory code 1,2,3,4,5, limit 5, menu phase.
// A stalled result holds the core; the key register then stalls the input.
// Lockout lasts until reset.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller
  import kcl_pkg::*;
#(
  parameter int CODE_SLOTS = DEFAULT_CODE_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  // key channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] key_code,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [2:0] phase,
  output logic [4:0] entered_count,
  output logic [3:0] failure_total,
  // lockout limit register
  input  logic       cfg_wen,
  input  logic [3:0] cfg_wdata
);

  logic       held_valid;
  logic [3:0] held_key;
  logic       slot_free;
  logic       advance;
  result_t    step_result;
  result_t    result_q;

  // Advance the held key whenever the result register can take its beat
  assign advance = held_valid && slot_free;

  kcl_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_code   (key_code),
    .advance    (advance),
    .held_valid (held_valid),
    .held_key   (held_key)
  );

  kcl_core #(
    .CODE_SLOTS (CODE_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .key       (held_key),
    .result    (step_result)
  );

  kcl_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .result_in  (step_result),
    .slot_free  (slot_free),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result_out (result_q)
  );

  // Drive result fields
  assign event_res     = result_q.event_res;
  assign phase         = result_q.phase;
  assign entered_count = result_q.entered_count;
  assign failure_total = result_q.failure_total;

`ifndef SYNTHESIS
  // A key moved into the core always shows up as a result beat next cycle
  a_advance_gives_beat: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced key produced no result beat");

  // A grant always clears the failure count
  a_grant_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_GRANTED) |-> (failure_total == 4'd0))
    else $error("grant with non-zero failure count");

  // Lockout event leaves the block locked
  a_lock_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_LOCKED) |-> (phase == PHASE_LOCKED))
    else $error("lockout event without locked phase");

  // Held keys are only reported on a plain key-taken beat
  a_count_on_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entered_count != 5'd0) |-> (event_res == EV_TAKEN))
    else $error("non-zero entry count on a closing beat");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keypad_code_lock_controller
// Drives decoded keys through the valid/stall channel. A behavioural model of
// the lock predicts one result beat per accepted key, and each returned beat
// is compared field by field. The run covers the factory code, verify and
// change sequences, over-long entries and back-pressure. It ends with lockout.
// ----------------------------------------------------------------------------
module testbench;
  import kcl_pkg::*;

  localparam int SLOTS     = DEFAULT_CODE_SLOTS;
  localparam int CODE_W    = 4 * SLOTS;
  localparam int LONG_HOLD = 300;   // cycles of result stall in the pressure test
  localparam int ERR_PRINTS = 40;   // mismatch lines printed before going quiet

  // Clock and synchronous reset; every block input starts at a known value
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [3:0] key_code  = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] event_res;
  logic [2:0] phase;
  logic [4:0] entered_count;
  logic [3:0] failure_total;
  logic       cfg_wen   = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  keypad_code_lock_controller dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .key_code      (key_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .phase         (phase),
    .entered_count (entered_count),
    .failure_total (failure_total),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Lock model: its own copy of the lock state, advanced once per accepted key.
  // Codes are kept as packed nibble vectors, key i in bits [4*i +: 4].
  // --------------------------------------------------------------------------
  logic [2:0]        lock_phase  = PHASE_MENU;
  logic [CODE_W-1:0] stored_keys = 64'h0000_0000_0005_4321;   // factory 1,2,3,4,5
  int                stored_len  = RESET_CODE_LEN;
  logic [CODE_W-1:0] entry_buf   = '0;
  int                entry_len   = 0;
  logic [CODE_W-1:0] first_buf   = '0;
  int                first_len   = 0;
  logic [3:0]        miss_count  = 4'd0;
  logic [3:0]        limit_reg   = LIMIT_RESET;

  // Results still owed by the block, oldest first
  result_t pending_results[$];

  int  keys_sent   = 0;
  int  burst_left  = 0;
  int  error_count = 0;
  bit  hold_req    = 1'b0;
  bit  hold_active = 1'b0;

  // Codes match on equal length and equal keys over that length only
  function automatic bit same_keys(input logic [CODE_W-1:0] a, input int alen,
                                   input logic [CODE_W-1:0] b, input int blen);
    logic [CODE_W-1:0] mask;
    if (alen != blen) return 1'b0;
    mask = (alen >= SLOTS) ? '1 : ((CODE_W'(1) << (4 * alen)) - CODE_W'(1));
    return ((a ^ b) & mask) == '0;
  endfunction

  // Advance the lock by one key and return the beat it should produce
  function automatic result_t step_lock(input logic [3:0] k);
    result_t    r;
    logic [3:0] lim;
    r.event_res     = EV_TAKEN;
    r.entered_count = 5'd0;
    if (lock_phase == PHASE_MENU) begin
      if (k == KEY_STAR) begin
        lock_phase = PHASE_VERIFY;
        entry_len  = 0;
      end else if (k == KEY_HASH) begin
        lock_phase = PHASE_OLD;
        entry_len  = 0;
      end else begin
        r.event_res = EV_IGNORED;
      end
    end else if (lock_phase == PHASE_LOCKED) begin
      r.event_res = EV_IGNORED;
    end else if (k != KEY_STAR && entry_len < SLOTS) begin
      // Hash and the unused codes are plain keys inside an entry
      entry_buf[4 * entry_len +: 4] = k;
      entry_len++;
      r.entered_count = 5'(entry_len);
    end else begin
      // Star, or any key once the entry is full, ends the entry and is dropped
      case (lock_phase)
        PHASE_VERIFY: begin
          if (same_keys(entry_buf, entry_len, stored_keys, stored_len)) begin
            miss_count  = 4'd0;
            r.event_res = EV_GRANTED;
            lock_phase  = PHASE_MENU;
          end else begin
            lim = (limit_reg == 4'd0) ? 4'd1 : limit_reg;
            if (miss_count < MAX_FAILURES) miss_count++;
            if (miss_count >= lim) begin
              r.event_res = EV_LOCKED;
              lock_phase  = PHASE_LOCKED;
            end else begin
              r.event_res = EV_RETRY;
              lock_phase  = PHASE_MENU;
            end
          end
        end
        PHASE_OLD: begin
          if (same_keys(entry_buf, entry_len, stored_keys, stored_len)) begin
            lock_phase = PHASE_NEW;
          end else begin
            r.event_res = EV_OLD_WRONG;
            lock_phase  = PHASE_MENU;
          end
        end
        PHASE_NEW: begin
          first_buf  = entry_buf;
          first_len  = entry_len;
          lock_phase = PHASE_CONFIRM;
        end
        default: begin
          if (same_keys(entry_buf, entry_len, first_buf, first_len)) begin
            stored_keys = entry_buf;
            stored_len  = entry_len;
            r.event_res = EV_CHANGED;
          end else begin
            r.event_res = EV_MISMATCH;
          end
          lock_phase = PHASE_MENU;
        end
      endcase
      entry_len = 0;
    end
    r.phase         = lock_phase;
    r.failure_total = miss_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Key sender: one beat per call. Bursts of random length, each followed by a
  // gap with valid low; now and then a long burst runs with no idling at all.
  // --------------------------------------------------------------------------
  task automatic send_key(input logic [3:0] k);
    in_valid <= 1'b1;
    key_code <= k;
    do @(posedge clk); while (in_stall);
    // Beat accepted at this edge: predict it now, in acceptance order
    pending_results.push_back(step_lock(k));
    keys_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Type a code, then the key that closes the entry: star, or for a full
  // entry any key at all
  task automatic enter_code(input logic [CODE_W-1:0] keys, input int len);
    for (int i = 0; i < len; i++) send_key(keys[4 * i +: 4]);
    send_key((len >= SLOTS) ? 4'($urandom_range(0, 15)) : KEY_STAR);
  endtask

  // Drop valid, let every owed beat come back, then allow for the pipeline
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    limit_reg  = v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Mostly digits; hash and the unused codes now and then, never star
  function automatic logic [3:0] non_star_key();
    if ($urandom_range(0, 4) == 0) return 4'($urandom_range(11, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  // Short codes mostly, with the empty and the full-length code kept in reach
  function automatic void random_code(output logic [CODE_W-1:0] keys, output int len);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)      len = 0;
    else if (r < 7)  len = r;
    else if (r < 9)  len = $urandom_range(7, 13);
    else             len = $urandom_range(14, SLOTS);
    keys = '0;
    for (int i = 0; i < SLOTS; i++) keys[4 * i +: 4] = non_star_key();
  endfunction

  // --------------------------------------------------------------------------
  // Random traffic: mostly well-formed verify and change sequences, with some
  // menu noise and abandoned change entries. Verify misses are only made
  // while they cannot lock the block, since lockout ends all useful traffic.
  // --------------------------------------------------------------------------
  task automatic run_sequences(input int n_keys);
    logic [CODE_W-1:0] code;
    int                len;
    int                pick;
    int                idx;
    int                stop_at;
    int                lim_now;
    stop_at = keys_sent + n_keys;
    while (keys_sent < stop_at) begin
      // Close any change left open by noise; star never opens a verify here
      while (lock_phase != PHASE_MENU) send_key(KEY_STAR);
      pick    = $urandom_range(0, 99);
      lim_now = (limit_reg == 4'd0) ? 1 : int'(limit_reg);
      if (pick < 40) begin
        // Verify attempt
        send_key(KEY_STAR);
        if ($urandom_range(0, 99) < 60 || int'(miss_count) + 1 >= lim_now) begin
          code = stored_keys;
          len  = stored_len;
        end else begin
          random_code(code, len);
        end
        enter_code(code, len);
      end else if (pick < 80) begin
        // Code change: old code, new code, confirmation
        send_key(KEY_HASH);
        if ($urandom_range(0, 99) < 75) begin
          code = stored_keys;
          len  = stored_len;
        end else begin
          random_code(code, len);
        end
        enter_code(code, len);
        if (lock_phase == PHASE_NEW) begin
          random_code(code, len);
          enter_code(code, len);
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            random_code(code, len);
          end else if (pick < 3 && len > 0) begin
            idx = $urandom_range(0, len - 1);
            code[4 * idx +: 4] = non_star_key();
          end
          enter_code(code, len);
        end
      end else if (pick < 90) begin
        // Menu noise: ignored keys, or a stray hash that opens a change
        repeat ($urandom_range(1, 4)) send_key(non_star_key());
      end else begin
        // Abandoned change, sometimes running past a full entry
        send_key(KEY_HASH);
        repeat ($urandom_range(1, 20)) send_key(non_star_key());
      end
    end
    while (lock_phase != PHASE_MENU) send_key(KEY_STAR);
  endtask

  // --------------------------------------------------------------------------
  // Result stall: segments of random length, each with its own stall density
  // (none, light, half, heavy). On request, hold off for a long counted stretch.
  // --------------------------------------------------------------------------
  initial begin : result_stall_pattern
    int seg_len;
    int pct;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        for (int n = 0; n < LONG_HOLD; n++) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        hold_active = 1'b0;
      end else begin
        seg_len = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 50;
          default: pct = 85;
        endcase
        repeat (seg_len) begin
          @(posedge clk);
          out_stall <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted beat against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      if (error_count <= ERR_PRINTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= ERR_PRINTS)
          $display("%0t: beat with nothing expected: expected none, got event %0d phase %0d",
                   $time, event_res, phase);
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", want.event_res, event_res);
        check_field("phase", want.phase, phase);
        check_field("entered_count", want.entered_count, entered_count);
        check_field("failure_total", want.failure_total, failure_total);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Factory state: ignored menu keys, the factory code, odd keys inside an
  // entry, and a change to the empty code that is then verified
  task automatic test_factory_code();
    send_key(4'd0);
    send_key(4'd9);
    send_key(4'd12);
    send_key(4'd15);
    send_key(KEY_STAR);
    for (int d = 1; d <= 5; d++) send_key(4'(d));
    send_key(KEY_STAR);
    send_key(KEY_STAR);
    send_key(KEY_HASH);
    send_key(4'd15);
    send_key(KEY_STAR);
    send_key(KEY_HASH);
    for (int d = 1; d <= 5; d++) send_key(4'(d));
    send_key(KEY_STAR);
    send_key(KEY_STAR);
    send_key(KEY_STAR);
    send_key(KEY_STAR);
    send_key(KEY_STAR);
  endtask

  task automatic test_random(input logic [3:0] limit, input int n_keys);
    settle_idle();
    write_limit(limit);
    run_sequences(n_keys);
  endtask

  // Hold the result side off for a long stretch while keys keep coming, so
  // the pipeline fills and the key channel stalls
  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    run_sequences(80);
  endtask

  // Build up misses, then drop the limit to zero, below the count: the next
  // miss locks, and every key after that is ignored
  task automatic test_lockout();
    logic [CODE_W-1:0] wrong;
    int                wrong_len;
    settle_idle();
    write_limit(4'd15);
    send_key(KEY_STAR);
    enter_code(stored_keys, stored_len);
    wrong     = stored_keys;
    wrong_len = (stored_len == SLOTS) ? 0 : stored_len + 1;
    if (wrong_len > 0) wrong[4 * (wrong_len - 1) +: 4] = 4'd7;
    repeat (3) begin
      send_key(KEY_STAR);
      enter_code(wrong, wrong_len);
    end
    settle_idle();
    write_limit(4'd0);
    send_key(KEY_STAR);
    enter_code(wrong, wrong_len);
    send_key(KEY_STAR);
    enter_code(stored_keys, stored_len);
    send_key(KEY_HASH);
    send_key(4'd0);
    send_key(4'd9);
    send_key(4'd15);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_factory_code();
    test_random(4'd15, 420);
    test_random(4'd1, 300);
    test_random(4'($urandom_range(2, 14)), 380);
    test_backpressure();
    test_random(LIMIT_RESET, 330);
    test_lockout();
    settle_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("keypad_code_lock_controller: match");
    end else begin
      $display("keypad_code_lock_controller: mismatch");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("keypad_code_lock_controller: mismatch");
    $finish;
  end

endmodule
